@@ sv/gha_pkg.sv @@
// Shared types, constants and helpers for the generational handle allocator.
package gha_pkg;

  localparam int unsigned SLOT_COUNT = 256;
  localparam int unsigned IdxW = $clog2(SLOT_COUNT);
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned GenW = 32;

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_RELEASE  = 2'd1,
    REQ_VALIDATE = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [7:0]  handle_index;
    logic [31:0] handle_generation;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic        is_valid;
    logic [7:0]  out_index;
    logic [31:0] out_generation;
  } rsp_t;

  typedef struct packed {
    logic            alive;
    logic [GenW-1:0] gen;
  } slot_t;

  function automatic logic [GenW-1:0] adv_gen(logic [GenW-1:0] g);
    logic [GenW-1:0] n;
    n = g + GenW'(1);
    return (n == '0) ? GenW'(1) : n;
  endfunction

endpackage

@@ sv/gha_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module gha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ sv/generational_handle_allocator_unit.sv @@
// Generational handle allocator: slot RAM, free-stack RAM and request sequencer.
// Result strobe in the cycle after acceptance for fresh allocate, pool full, early-rejected
//   handles and clear of an empty pool; allocate from the free stack: stack read, slot read,
//   slot write; release/validate: slot read and check; clear: read and rewrite of each created
//   slot. One transaction at a time; busy is high until the result is written; results cannot
//   be stalled. Reset: counters and control clear at once; RAM contents are not cleared.
module generational_handle_allocator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  gha_pkg::req_t req_i,
  output logic          done_o,
  output gha_pkg::rsp_t rsp_o
);
  import gha_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_AGEN = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] free_depth_q, free_depth_d;
  logic [CntW-1:0] created_q, created_d;
  logic [IdxW-1:0] cidx_q, cidx_d;
  req_t            req_q, req_d;
  rsp_t            rsp_q, rsp_d;
  logic            done_q, done_d;

  logic            gen_we, gen_re;
  logic [IdxW-1:0] gen_waddr, gen_raddr;
  slot_t           gen_wdata, gen_rdata;
  logic            stk_we, stk_re;
  logic [IdxW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic            accept;
  logic            hdl_pre_ok;
  logic [GenW-1:0] alloc_gen;
  logic [CntW-1:0] cidx_nxt;

  gha_ram #(.Width($bits(slot_t)), .Depth(SLOT_COUNT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (gen_re),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  gha_ram #(.Width(IdxW), .Depth(SLOT_COUNT)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign hdl_pre_ok = (req_i.handle_generation != '0) &&
                      (32'(req_i.handle_index) < 32'(created_q));
  assign alloc_gen  = (gen_rdata.gen == '0) ? GenW'(1) : gen_rdata.gen;
  assign cidx_nxt   = CntW'(cidx_q) + CntW'(1);

  always_comb begin
    state_d      = state_q;
    free_depth_d = free_depth_q;
    created_d    = created_q;
    cidx_d       = cidx_q;
    req_d        = req_q;
    rsp_d        = rsp_q;
    done_d       = 1'b0;
    gen_we       = 1'b0;
    gen_waddr    = '0;
    gen_wdata    = '0;
    gen_re       = 1'b0;
    gen_raddr    = '0;
    stk_we       = 1'b0;
    stk_waddr    = '0;
    stk_wdata    = '0;
    stk_re       = 1'b0;
    stk_raddr    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d = req_i;
          rsp_d = '{status: STAT_OK, is_valid: 1'b0, out_index: '0, out_generation: '0};
          unique case (req_i.req_type)
            REQ_ALLOC: begin
              if (free_depth_q != '0) begin
                stk_re       = 1'b1;
                stk_raddr    = IdxW'(free_depth_q - CntW'(1));
                free_depth_d = free_depth_q - CntW'(1);
                state_d      = ST_POP;
              end else if (32'(created_q) < SLOT_COUNT) begin
                gen_we    = 1'b1;
                gen_waddr = IdxW'(created_q);
                gen_wdata = '{alive: 1'b1, gen: GenW'(1)};
                created_d = created_q + CntW'(1);
                rsp_d.out_index      = 8'(created_q);
                rsp_d.out_generation = GenW'(1);
                done_d    = 1'b1;
              end else begin
                rsp_d.status = STAT_FULL;
                done_d       = 1'b1;
              end
            end
            REQ_RELEASE, REQ_VALIDATE: begin
              if (hdl_pre_ok) begin
                gen_re    = 1'b1;
                gen_raddr = IdxW'(req_i.handle_index);
                state_d   = ST_CHK;
              end else begin
                rsp_d.status = STAT_INVALID;
                done_d       = 1'b1;
              end
            end
            REQ_CLEAR: begin
              if (created_q == '0) begin
                free_depth_d = '0;
                done_d       = 1'b1;
              end else begin
                gen_re    = 1'b1;
                gen_raddr = '0;
                cidx_d    = '0;
                state_d   = ST_CLR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        gen_re    = 1'b1;
        gen_raddr = stk_rdata;
        cidx_d    = stk_rdata;
        state_d   = ST_AGEN;
      end
      ST_AGEN: begin
        gen_we    = 1'b1;
        gen_waddr = cidx_q;
        gen_wdata = '{alive: 1'b1, gen: alloc_gen};
        rsp_d.out_index      = 8'(cidx_q);
        rsp_d.out_generation = alloc_gen;
        done_d    = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_CHK: begin
        if (gen_rdata.alive && (gen_rdata.gen == req_q.handle_generation)) begin
          rsp_d.is_valid = 1'b1;
          if (req_q.req_type == REQ_RELEASE) begin
            gen_we    = 1'b1;
            gen_waddr = IdxW'(req_q.handle_index);
            gen_wdata = '{alive: 1'b0, gen: adv_gen(gen_rdata.gen)};
            if (32'(free_depth_q) < SLOT_COUNT) begin
              stk_we       = 1'b1;
              stk_waddr    = IdxW'(free_depth_q);
              stk_wdata    = IdxW'(req_q.handle_index);
              free_depth_d = free_depth_q + CntW'(1);
            end
          end
        end else begin
          rsp_d.status = STAT_INVALID;
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CLR: begin
        gen_we    = 1'b1;
        gen_waddr = cidx_q;
        gen_wdata = '{alive: 1'b0, gen: adv_gen(gen_rdata.gen)};
        stk_we    = 1'b1;
        stk_waddr = cidx_q;
        stk_wdata = cidx_q;
        if (cidx_nxt == created_q) begin
          free_depth_d = created_q;
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          gen_re    = 1'b1;
          gen_raddr = IdxW'(cidx_nxt);
          cidx_d    = IdxW'(cidx_nxt);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      free_depth_q <= '0;
      created_q    <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_depth_q <= free_depth_d;
      created_q    <= created_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q <= cidx_d;
    req_q  <= req_d;
    rsp_q  <= rsp_d;
  end

endmodule

@@ test/gha_handle_checker.sv @@
// Checker for the generational handle allocator: slot-map predictor and result comparison.
module gha_handle_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  gha_pkg::req_t req_i,
  input  logic          done_i,
  input  gha_pkg::rsp_t rsp_i,
  output int unsigned   err_count_o,
  output int unsigned   pending_o,
  output int unsigned   checked_o,
  output int unsigned   full_o,
  output int unsigned   clear_o,
  output int unsigned   reuse_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gha_pkg::*;

  logic [GenW-1:0] gen_tab   [SLOT_COUNT];
  logic            alive_tab [SLOT_COUNT];
  logic [IdxW-1:0] free_list [SLOT_COUNT];
  int unsigned     free_top;
  int unsigned     created;

  rsp_t awaited_rsp_q[$];
  rsp_t want;

  function automatic logic [GenW-1:0] bump_gen(logic [GenW-1:0] g);
    logic [GenW-1:0] nxt;
    nxt = g + 1'b1;
    if (nxt == '0) begin
      nxt = 1;
    end
    return nxt;
  endfunction

  function automatic logic live_handle(logic [7:0] idx, logic [31:0] gen);
    if (gen == '0 || idx >= created) begin
      return 1'b0;
    end
    return alive_tab[idx] && gen_tab[idx] == gen;
  endfunction

  function automatic rsp_t slot_map_outcome(req_t rq);
    rsp_t            r;
    logic [IdxW-1:0] s;
    r        = '0;
    r.status = STAT_OK;
    case (rq.req_type)
      REQ_ALLOC: begin
        if (free_top > 0) begin
          free_top--;
          s = free_list[free_top];
          reuse_o++;
        end else if (created < SLOT_COUNT) begin
          s          = IdxW'(created);
          created++;
          gen_tab[s] = 1;
        end else begin
          r.status = STAT_FULL;
          full_o++;
          return r;
        end
        if (gen_tab[s] == '0) begin
          gen_tab[s] = 1;
        end
        alive_tab[s]     = 1'b1;
        r.out_index      = s;
        r.out_generation = gen_tab[s];
      end
      REQ_RELEASE, REQ_VALIDATE: begin
        if (live_handle(rq.handle_index, rq.handle_generation)) begin
          r.is_valid = 1'b1;
          if (rq.req_type == REQ_RELEASE) begin
            alive_tab[rq.handle_index] = 1'b0;
            gen_tab[rq.handle_index]   = bump_gen(gen_tab[rq.handle_index]);
            if (free_top < SLOT_COUNT) begin
              free_list[free_top] = rq.handle_index;
              free_top++;
            end
          end
        end else begin
          r.status = STAT_INVALID;
        end
      end
      default: begin
        clear_o++;
        free_top = 0;
        for (int i = 0; i < created; i++) begin
          alive_tab[i]        = 1'b0;
          gen_tab[i]          = bump_gen(gen_tab[i]);
          free_list[free_top] = IdxW'(i);
          free_top++;
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    err_count_o++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        gen_tab[i]   = '0;
        alive_tab[i] = 1'b0;
        free_list[i] = '0;
      end
      free_top = 0;
      created  = 0;
      awaited_rsp_q.delete();
      err_count_o = 0;
      pending_o   = 0;
      checked_o   = 0;
      full_o      = 0;
      clear_o     = 0;
      reuse_o     = 0;
    end else begin
      if (done_i) begin
        if (awaited_rsp_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding", 32'(rsp_i.status), '0);
        end else begin
          want = awaited_rsp_q.pop_front();
          checked_o++;
          if (rsp_i.status !== want.status) begin
            report_mismatch("status", 32'(rsp_i.status), 32'(want.status));
          end
          if (rsp_i.is_valid !== want.is_valid) begin
            report_mismatch("is_valid", 32'(rsp_i.is_valid), 32'(want.is_valid));
          end
          if (rsp_i.out_index !== want.out_index) begin
            report_mismatch("out_index", 32'(rsp_i.out_index), 32'(want.out_index));
          end
          if (rsp_i.out_generation !== want.out_generation) begin
            report_mismatch("out_generation", rsp_i.out_generation, want.out_generation);
          end
        end
      end
      if (start_i && !busy_i) begin
        awaited_rsp_q.insert(awaited_rsp_q.size(), slot_map_outcome(req_i));
      end
      pending_o = awaited_rsp_q.size();
    end
  end

endmodule

@@ test/tb_generational_handle_allocator_unit.sv @@
// Testbench top for the generational handle allocator: stimulus, clock, reset and verdict.
module tb_generational_handle_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gha_pkg::*;

  localparam int unsigned N_RANDOM    = 1375;
  localparam int unsigned CALM_TAIL   = 300;
  localparam int unsigned DRAIN_WAIT  = 300;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    logic [7:0]  idx;
    logic [31:0] gen;
  } handle_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;

  int unsigned err_count, pending, checked, full_hits, clears, reuses;
  int unsigned cycles = 0;
  logic        allow_idle;
  handle_t     handle_q[$];

  generational_handle_allocator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  gha_handle_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .done_i      (done_o),
    .rsp_i       (rsp_o),
    .err_count_o (err_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .full_o      (full_hits),
    .clear_o     (clears),
    .reuse_o     (reuses)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_generational_handle_allocator_unit: done, errors");
      $finish;
    end
  end

  // handles granted by the block, used to build release/validate traffic
  always @(posedge clk_i) begin
    if (rst_ni && done_o && rsp_o.status == STAT_OK && rsp_o.out_generation != '0) begin
      handle_q.insert(handle_q.size(),
                      handle_t'{idx: rsp_o.out_index, gen: rsp_o.out_generation});
    end
  end

  task automatic issue(req_type_e op, logic [7:0] idx, logic [31:0] gen);
    req_i <= '{req_type: op, handle_index: idx, handle_generation: gen};
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if (allow_idle && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic issue_random(int unsigned n);
    int unsigned p, a, rl, v, span, k;
    req_type_e   op;
    handle_t     h;
    if (n < 500) begin
      a = 75; rl = 10; v = 15;
    end else if (n < 1000) begin
      a = 35; rl = 30; v = 30;
    end else begin
      a = 50; rl = 25; v = 20;
    end
    p = $urandom_range(99);
    if (p < a) begin
      op = REQ_ALLOC;
    end else if (p < a + rl) begin
      op = REQ_RELEASE;
    end else if (p < a + rl + v) begin
      op = REQ_VALIDATE;
    end else begin
      op = REQ_CLEAR;
    end
    p = $urandom_range(99);
    if (handle_q.size() > 0 && p < 60) begin
      span = (handle_q.size() > 24) ? 23 : handle_q.size() - 1;
      k    = handle_q.size() - 1 - $urandom_range(span);
      h    = handle_q[k];
    end else if (handle_q.size() > 0 && p < 75) begin
      h     = handle_q[$urandom_range(handle_q.size() - 1)];
      h.gen = h.gen + $urandom_range(2) - 1;
    end else if (p < 85) begin
      h.idx = 8'($urandom_range(255));
      h.gen = $urandom_range(4);
    end else begin
      h.idx = 8'($urandom_range(255));
      h.gen = $urandom;
    end
    issue(op, h.idx, h.gen);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    allow_idle = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(REQ_CLEAR,    8'd0,   32'd0);
    issue(REQ_VALIDATE, 8'd0,   32'd1);
    issue(REQ_ALLOC,    8'd0,   32'd0);
    issue(REQ_ALLOC,    8'd0,   32'd0);
    issue(REQ_VALIDATE, 8'd0,   32'd1);
    issue(REQ_VALIDATE, 8'd0,   32'd0);
    issue(REQ_VALIDATE, 8'd1,   32'd2);
    issue(REQ_VALIDATE, 8'd255, 32'd1);
    issue(REQ_RELEASE,  8'd0,   32'd1);
    issue(REQ_RELEASE,  8'd0,   32'd1);
    issue(REQ_VALIDATE, 8'd0,   32'd2);
    issue(REQ_ALLOC,    8'd0,   32'd0);
    issue(REQ_RELEASE,  8'd1,   32'hFFFF_FFFF);
    issue(REQ_RELEASE,  8'd1,   32'd0);
    issue(REQ_CLEAR,    8'd0,   32'd0);
    issue(REQ_VALIDATE, 8'd0,   32'd2);
    issue(REQ_ALLOC,    8'd0,   32'd0);
    issue(REQ_ALLOC,    8'd0,   32'd0);
    issue(REQ_ALLOC,    8'd0,   32'd0);
    issue(REQ_RELEASE,  8'd2,   32'd1);
    issue(REQ_RELEASE,  8'd1,   32'd2);
    issue(REQ_ALLOC,    8'd0,   32'd0);
    issue(REQ_VALIDATE, 8'd255, 32'hFFFF_FFFF);
    issue(REQ_CLEAR,    8'd255, 32'hFFFF_FFFF);
    issue(REQ_ALLOC,    8'd255, 32'hFFFF_FFFF);

    for (int unsigned n = 0; n < N_RANDOM; n++) begin
      allow_idle = (n < N_RANDOM - CALM_TAIL);
      issue_random(n);
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("checked %0d transactions in %0d cycles", checked, cycles);
    $display("slots reused from free stack: %0d, pool-full rejects: %0d, clears: %0d",
             reuses, full_hits, clears);
    if (err_count == 0) begin
      $display("tb_generational_handle_allocator_unit: done, clean");
    end else begin
      $display("tb_generational_handle_allocator_unit: done, errors");
    end
    $finish;
  end

endmodule
